/* sv/rv32x_pkg.sv */
// Shared types and constants for the RV32 subset execute unit.
// No dependencies; imported by every module of the block but rv32x_ram.
`timescale 1ns / 1ps
`default_nettype none

package rv32x_pkg;

  // Default size of the byte memory, must be a multiple of four
  localparam int MEM_BYTES_DEF = 1 << 10;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [4:0] {
    OP_LB   = 5'd0,
    OP_LW   = 5'd1,
    OP_SB   = 5'd2,
    OP_SW   = 5'd3,
    OP_ADD  = 5'd4,
    OP_ADDI = 5'd5,
    OP_SUB  = 5'd6,
    OP_XOR  = 5'd7,
    OP_XORI = 5'd8,
    OP_SLLI = 5'd9,
    OP_SRLI = 5'd10,
    OP_MV   = 5'd11,
    OP_LI   = 5'd12,
    OP_NEG  = 5'd13,
    OP_NOT  = 5'd14,
    OP_JAL  = 5'd15,
    OP_J    = 5'd16,
    OP_JALR = 5'd17,
    OP_JR   = 5'd18
  } op_t;

  // Decoded outcome of one instruction, before the memory range check
  typedef struct packed {
    logic [31:0] npc;      // next pc when not halted
    logic        wr;       // register write from ALU or link
    logic [31:0] val;      // ALU or link value
    logic [31:0] addr;     // rs1 + imm
    logic        load;
    logic        store;
    logic        byte_op;  // LB or SB
  } exec_t;

endpackage

`default_nettype wire

/* sv/rv32x_ram.sv */
// Generic single write port RAM with a registered, enabled read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rv32x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/rv32x_alu.sv */
// Instruction decode and integer datapath: next pc, write-back value and
// effective address for one instruction. Depends on rv32x_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rv32x_alu
  import rv32x_pkg::*;
(
  input  wire logic [4:0]  op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] imm,
  input  wire logic [31:0] pc,
  output exec_t            res
);

  logic [31:0] sum;
  logic [31:0] pc4;

  assign sum = a + imm;
  assign pc4 = pc + PC_STEP;

  always_comb begin
    res      = '0;
    res.npc  = pc4;
    res.addr = sum;
    case (op)
      OP_LB: begin
        res.load    = 1'b1;
        res.byte_op = 1'b1;
      end
      OP_LW:   res.load = 1'b1;
      OP_SB: begin
        res.store   = 1'b1;
        res.byte_op = 1'b1;
      end
      OP_SW:   res.store = 1'b1;
      OP_ADD: begin
        res.wr  = 1'b1;
        res.val = a + b;
      end
      OP_ADDI: begin
        res.wr  = 1'b1;
        res.val = sum;
      end
      OP_SUB: begin
        res.wr  = 1'b1;
        res.val = a - b;
      end
      OP_XOR: begin
        res.wr  = 1'b1;
        res.val = a ^ b;
      end
      OP_XORI: begin
        res.wr  = 1'b1;
        res.val = a ^ imm;
      end
      OP_SLLI: begin
        res.wr  = 1'b1;
        res.val = a << imm[4:0];
      end
      OP_SRLI: begin
        res.wr  = 1'b1;
        res.val = a >> imm[4:0];
      end
      OP_MV: begin
        res.wr  = 1'b1;
        res.val = a;
      end
      OP_LI: begin
        res.wr  = 1'b1;
        res.val = imm;
      end
      OP_NEG: begin
        res.wr  = 1'b1;
        res.val = 32'd0 - a;
      end
      OP_NOT: begin
        res.wr  = 1'b1;
        res.val = ~a;
      end
      OP_JAL: begin
        res.wr  = 1'b1;
        res.val = pc4;
        res.npc = pc + imm;
      end
      OP_J:    res.npc = pc + imm;
      OP_JALR: begin
        res.wr  = 1'b1;
        res.val = pc4;
        res.npc = {sum[31:1], 1'b0};
      end
      OP_JR:   res.npc = {a[31:1], 1'b0};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/rv32_subset_execute_unit.sv */
// Top level of the RV32 subset execute unit: register file, byte memory,
// pc and the two-stage pipeline. Depends on rv32x_pkg, rv32x_ram, rv32x_alu.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | op dest_reg src_reg_a src_reg_b immediate
//  out     | out_valid / out_stall  | next_pc wb_valid wb_reg wb_value
//          |                        | mem_fault halted
//
// One request per cycle sustained while out is not stalled; each is registered
// into stage A by the register file read, then into stage B by the data memory
// read, the registered read ports of the two memories. Register values are
// forwarded past the register file, so dependent requests follow back to back.
// After reset a clearing pass zeroes the byte memory row by row; in_stall is
// high meanwhile. A stall on out holds the result stage, and in_stall rises
// once the first stage is full as well.
`timescale 1ns / 1ps
`default_nettype none

module rv32_subset_execute_unit
  import rv32x_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [4:0]         op,
  input  wire logic [4:0]         dest_reg,
  input  wire logic [4:0]         src_reg_a,
  input  wire logic [4:0]         src_reg_b,
  input  wire logic signed [31:0] immediate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      next_pc,
  output logic                    wb_valid,
  output logic [4:0]              wb_reg,
  output logic [31:0]             wb_value,
  output logic                    mem_fault,
  output logic                    halted
);

  // memory is four byte banks so an unaligned word is one row per bank
  localparam int ROWS  = MEM_BYTES / 4;
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [31:0] LAST_B = 32'(MEM_BYTES - 1);
  localparam logic [31:0] LAST_W = 32'(MEM_BYTES - 4);
  localparam logic [31:0] SP_RST = 32'(MEM_BYTES);

  // handshake
  logic in_acc, a_adv, b_free, b_take;

  // clearing pass
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  // register file
  logic [31:0] rf_valid;
  logic [31:0] rf_q1, rf_q2;

  // last register write, covers the write that lands on the read edge
  logic        l_valid;
  logic [4:0]  l_rd;
  logic [31:0] l_val;

  logic [31:0] pc;

  // stage A
  logic        a_full;
  logic [4:0]  a_op, a_rd, a_rs1, a_rs2;
  logic [31:0] a_imm;
  logic        a_rv1, a_rv2;

  // stage B (result)
  logic        b_full;
  logic [31:0] b_npc;
  logic        b_wr;
  logic [4:0]  b_rd;
  logic [31:0] b_val;
  logic        b_load, b_byte, b_fault;
  logic [1:0]  b_off;

  logic [31:0] b_wbv;
  logic [31:0] ld_val;
  logic [7:0]  ld_byte [4];

  logic [31:0] opa, opb;
  exec_t       ex;
  logic        a_halt, a_inrange, a_fault, a_wr, st_go;
  logic [31:0] a_npc;
  logic [1:0]  a_off;
  logic [ROW_W-1:0] base_row;

  logic             bank_we    [4];
  logic [ROW_W-1:0] bank_waddr [4];
  logic [ROW_W-1:0] bank_raddr [4];
  logic [7:0]       bank_wdata [4];
  logic [7:0]       bank_q     [4];

  assign b_take   = b_full & ~out_stall;
  assign b_free   = ~b_full | ~out_stall;
  assign a_adv    = a_full & b_free;
  assign in_stall = clearing | (a_full & ~b_free);
  assign in_acc   = in_valid & ~in_stall;

  // ---------------------------------------------------------------- reg file
  rv32x_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (b_take & b_wr),
    .waddr (b_rd),
    .wdata (b_wbv),
    .re    (in_acc),
    .raddr (src_reg_a),
    .rdata (rf_q1)
  );

  rv32x_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (b_take & b_wr),
    .waddr (b_rd),
    .wdata (b_wbv),
    .re    (in_acc),
    .raddr (src_reg_b),
    .rdata (rf_q2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      l_valid  <= 1'b0;
    end else if (b_take && b_wr) begin
      rf_valid[b_rd] <= 1'b1;
      l_valid        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take && b_wr) begin
      l_rd  <= b_rd;
      l_val <= b_wbv;
    end
  end

  // x0 reads zero, else newest first: result stage, last write, then the array or its reset value
  function automatic logic [31:0] fwd(input logic [4:0] rs, input logic [31:0] q,
                                      input logic v);
    logic [31:0] r;
    if (rs == 5'd0) begin
      r = '0;
    end else if (b_full && b_wr && b_rd == rs) begin
      r = b_wbv;
    end else if (l_valid && l_rd == rs) begin
      r = l_val;
    end else if (v) begin
      r = q;
    end else if (rs == 5'd2) begin
      r = SP_RST;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // ----------------------------------------------------------------- stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_full <= 1'b0;
    end else if (in_acc) begin
      a_full <= 1'b1;
    end else if (a_adv) begin
      a_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op  <= op;
      a_rd  <= dest_reg;
      a_rs1 <= src_reg_a;
      a_rs2 <= src_reg_b;
      a_imm <= immediate;
      a_rv1 <= rf_valid[src_reg_a];
      a_rv2 <= rf_valid[src_reg_b];
    end
  end

  // fwd reads the forwarding registers directly, so evaluate it in a process
  always_comb begin
    opa = fwd(a_rs1, rf_q1, a_rv1);
    opb = fwd(a_rs2, rf_q2, a_rv2);
  end

  rv32x_alu u_alu (
    .op  (a_op),
    .a   (opa),
    .b   (opb),
    .imm (a_imm),
    .pc  (pc),
    .res (ex)
  );

  assign a_halt    = pc[31];
  assign a_inrange = ex.byte_op ? (ex.addr <= LAST_B) : (ex.addr <= LAST_W);
  assign a_fault   = ~a_halt & (ex.load | ex.store) & ~a_inrange;
  assign a_wr      = ~a_halt & (a_rd != 5'd0) & (ex.wr | (ex.load & a_inrange));
  assign a_npc     = a_halt ? pc : ex.npc;
  assign st_go     = a_adv & ~a_halt & ex.store & a_inrange;
  assign a_off     = ex.addr[1:0];
  assign base_row  = ex.addr[ROW_W+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (a_adv) begin
      pc <= a_npc;
    end
  end

  // ------------------------------------------------------------- byte memory
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]  lane;
    logic        wrap;
    logic [31:0] shifted;

    // byte lane of the word held by this bank; banks below the offset wrap
    assign lane    = 2'(k) - a_off;
    assign wrap    = 2'(k) < a_off;
    assign shifted = opb >> {lane, 3'b000};

    assign bank_raddr[k] = base_row + ROW_W'(wrap);
    assign bank_we[k]    = clearing | (st_go & (~ex.byte_op | (lane == 2'd0)));
    assign bank_waddr[k] = clearing ? clr_row : bank_raddr[k];
    assign bank_wdata[k] = clearing ? 8'd0 : shifted[7:0];

    rv32x_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (bank_we[k]),
      .waddr (bank_waddr[k]),
      .wdata (bank_wdata[k]),
      .re    (a_adv),
      .raddr (bank_raddr[k]),
      .rdata (bank_q[k])
    );

    assign ld_byte[k] = bank_q[b_off + 2'(k)];
  end

  // ----------------------------------------------------------------- stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_full <= 1'b0;
    end else if (a_adv) begin
      b_full <= 1'b1;
    end else if (b_take) begin
      b_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_npc   <= a_npc;
      b_wr    <= a_wr;
      b_rd    <= a_wr ? a_rd : 5'd0;
      b_val   <= a_wr ? ex.val : 32'd0;
      b_load  <= a_wr & ex.load;
      b_byte  <= ex.byte_op;
      b_off   <= a_off;
      b_fault <= a_fault;
    end
  end

  assign ld_val = b_byte ? {{24{ld_byte[0][7]}}, ld_byte[0]}
                         : {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
  assign b_wbv  = b_load ? ld_val : b_val;

  assign out_valid = b_full;
  assign next_pc   = b_npc;
  assign wb_valid  = b_wr;
  assign wb_reg    = b_rd;
  assign wb_value  = b_wbv;
  assign mem_fault = b_fault;
  assign halted    = b_npc[31];

endmodule

`default_nettype wire

/* dv/rv32x_retire_checker.sv */
// Retirement checker for the RV32 subset execute unit: keeps its own register
// file, byte memory and pc, predicts each result and compares. Uses rv32x_pkg.
`timescale 1ns / 1ps

module rv32x_retire_checker
  import rv32x_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [4:0]  op,
  input  wire logic [4:0]  dest_reg,
  input  wire logic [4:0]  src_reg_a,
  input  wire logic [4:0]  src_reg_b,
  input  wire logic [31:0] immediate,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] next_pc,
  input  wire logic        wb_valid,
  input  wire logic [4:0]  wb_reg,
  input  wire logic [31:0] wb_value,
  input  wire logic        mem_fault,
  input  wire logic        halted,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [31:0] npc;
    logic        wbv;
    logic [4:0]  wreg;
    logic [31:0] wval;
    logic        fault;
    logic        halt;
  } retire_t;

  logic [31:0] regs [32];
  logic [7:0]  dmem [MEM_BYTES];
  logic [31:0] pc;
  retire_t     retire_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic bit fits(logic [31:0] addr, logic [31:0] len);
    return addr < 32'(MEM_BYTES) && len <= 32'(MEM_BYTES) - addr;
  endfunction

  // Executes one request against the local state and returns its retirement
  function automatic retire_t predict_retire(logic [4:0] opc, logic [4:0] rd,
                                             logic [4:0] rs1, logic [4:0] rs2,
                                             logic [31:0] imm);
    logic [31:0] a, b, npc, addr, val;
    logic        wr, fault;
    retire_t     r;
    a = regs[rs1];
    b = regs[rs2];
    npc = pc + PC_STEP;
    addr = a + imm;
    val = '0;
    wr = 1'b0;
    fault = 1'b0;
    r = '0;
    if (pc[31]) begin
      // halted: request ignored, pc frozen
      r.npc = pc;
      r.halt = 1'b1;
      return r;
    end
    case (op_t'(opc))
      OP_LB: begin
        if (fits(addr, 32'd1)) begin
          val = {{24{dmem[addr][7]}}, dmem[addr]};
          wr = 1'b1;
        end else fault = 1'b1;
      end
      OP_LW: begin
        if (fits(addr, 32'd4)) begin
          val = {dmem[addr + 32'd3], dmem[addr + 32'd2], dmem[addr + 32'd1], dmem[addr]};
          wr = 1'b1;
        end else fault = 1'b1;
      end
      OP_SB: begin
        if (fits(addr, 32'd1)) dmem[addr] = b[7:0];
        else fault = 1'b1;
      end
      OP_SW: begin
        if (fits(addr, 32'd4)) begin
          for (int i = 0; i < 4; i++) dmem[addr + 32'(i)] = b[8*i +: 8];
        end else fault = 1'b1;
      end
      OP_ADD:  begin val = a + b;            wr = 1'b1; end
      OP_ADDI: begin val = a + imm;          wr = 1'b1; end
      OP_SUB:  begin val = a - b;            wr = 1'b1; end
      OP_XOR:  begin val = a ^ b;            wr = 1'b1; end
      OP_XORI: begin val = a ^ imm;          wr = 1'b1; end
      OP_SLLI: begin val = a << imm[4:0];    wr = 1'b1; end
      OP_SRLI: begin val = a >> imm[4:0];    wr = 1'b1; end
      OP_MV:   begin val = a;                wr = 1'b1; end
      OP_LI:   begin val = imm;              wr = 1'b1; end
      OP_NEG:  begin val = 32'd0 - a;        wr = 1'b1; end
      OP_NOT:  begin val = ~a;               wr = 1'b1; end
      OP_JAL: begin
        val = pc + PC_STEP;
        wr = 1'b1;
        npc = pc + imm;
      end
      OP_J:    npc = pc + imm;
      OP_JALR: begin
        val = pc + PC_STEP;
        wr = 1'b1;
        npc = (a + imm) & ~32'd1;
      end
      OP_JR:   npc = a & ~32'd1;
      default: ;
    endcase
    if (wr && rd != 5'd0) regs[rd] = val;
    else begin
      wr = 1'b0;
      rd = 5'd0;
      val = '0;
    end
    pc = npc;
    r.npc = npc;
    r.wbv = wr;
    r.wreg = rd;
    r.wval = val;
    r.fault = fault;
    r.halt = npc[31];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    retire_t want;
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] = '0;
      regs[2] = 32'(MEM_BYTES);
      for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
      pc = '0;
      retire_q.delete();
    end else begin
      // result side first: it always belongs to an older request
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual next_pc %h",
                   $time, next_pc);
          fail_count++;
        end else begin
          want = retire_q.pop_front();
          check_field("next_pc", want.npc, next_pc);
          check_field("wb_valid", want.wbv, wb_valid);
          check_field("wb_reg", want.wreg, wb_reg);
          check_field("wb_value", want.wval, wb_value);
          check_field("mem_fault", want.fault, mem_fault);
          check_field("halted", want.halt, halted);
        end
      end
      if (in_valid && !in_stall)
        retire_q.push_back(predict_retire(op, dest_reg, src_reg_a, src_reg_b, immediate));
    end
    pending = retire_q.size();
  end

endmodule

/* dv/tb_rv32_subset_execute_unit.sv */
// Testbench top for the RV32 subset execute unit: clock, reset, request
// stimulus, result back-pressure and verdict. Uses rv32x_pkg, rv32x_retire_checker.
`timescale 1ns / 1ps

module tb_rv32_subset_execute_unit;
  import rv32x_pkg::*;

  localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
  localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;
  localparam int RANDOM_ITEMS = 1770;
  localparam int QUIET_FROM   = 1600;
  localparam int DRAIN_AT     = 900;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 90;
  localparam int RUN_LIMIT_NS = 4_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [4:0]  op = '0;
  logic [4:0]  dest_reg = '0;
  logic [4:0]  src_reg_a = '0;
  logic [4:0]  src_reg_b = '0;
  logic signed [31:0] immediate = '0;
  logic        out_stall = 1'b0;

  logic        in_stall, out_valid, wb_valid, mem_fault, halted;
  logic signed [31:0] next_pc;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;

  int fail_count, pending;
  int sent = 0;
  bit quiet = 1'b0;

  // pc and LI-loaded registers as the stimulus sees them, so that jumps stay
  // non-negative and most memory requests land in range
  logic [31:0] gen_pc;
  logic [31:0] known_val [32];
  bit          known_ok [32];

  rv32_subset_execute_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .dest_reg(dest_reg), .src_reg_a(src_reg_a), .src_reg_b(src_reg_b),
    .immediate(immediate),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .wb_valid(wb_valid), .wb_reg(wb_reg), .wb_value(wb_value),
    .mem_fault(mem_fault), .halted(halted)
  );

  rv32x_retire_checker retire_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .dest_reg(dest_reg), .src_reg_a(src_reg_a), .src_reg_b(src_reg_b),
    .immediate(immediate),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .wb_valid(wb_valid), .wb_reg(wb_reg), .wb_value(wb_value),
    .mem_fault(mem_fault), .halted(halted),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  task automatic issue(logic [4:0] opc, logic [4:0] rd, logic [4:0] rs1,
                       logic [4:0] rs2, logic [31:0] imm);
    in_valid <= 1'b1;
    op <= opc;
    dest_reg <= rd;
    src_reg_a <= rs1;
    src_reg_b <= rs2;
    immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    case (opc)
      OP_J, OP_JAL: gen_pc = gen_pc + imm;
      OP_JALR:      gen_pc = (known_val[rs1] + imm) & ~32'd1;
      OP_JR:        gen_pc = known_val[rs1] & ~32'd1;
      default:      gen_pc = gen_pc + PC_STEP;
    endcase
    if (rd != 5'd0 && opc <= OP_JR && !(opc inside {OP_SB, OP_SW, OP_J, OP_JR})) begin
      known_ok[rd] = (opc == OP_LI);
      known_val[rd] = imm;
    end
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pause first so that the last accepted request is already counted
  task automatic drain();
    pause(1);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_known(logic [31:0] bound);
    logic [4:0] r;
    for (int t = 0; t < 6; t++) begin
      r = 5'($urandom_range(0, 31));
      if (known_ok[r] && known_val[r] < bound) return r;
    end
    return 5'd0;
  endfunction

  task automatic random_request();
    int          r, target;
    logic [4:0]  o, rd, rs1, rs2;
    logic [31:0] imm;
    r = $urandom_range(0, 99);
    rd = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    imm = $urandom;
    o = OP_ADD;
    if (r < 32) begin
      // loads and stores, mostly in range, crowding the ends of memory
      o = 5'($urandom_range(OP_LB, OP_SW));
      rs1 = pick_known(32'd2048);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: target = $urandom_range(0, 63);
        4, 5:       target = $urandom_range(MEM_BYTES_DEF - 12, MEM_BYTES_DEF + 3);
        6:          target = int'($urandom_range(0, 7)) - 8;
        default:    target = $urandom_range(0, MEM_BYTES_DEF - 1);
      endcase
      imm = 32'(target) - known_val[rs1];
    end else if (r < 72) begin
      o = 5'($urandom_range(OP_ADD, OP_NOT));
      if ($urandom_range(0, 7) == 0) imm = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (r < 80) begin
      o = OP_LI;
      if ($urandom_range(0, 1) == 1) imm = $urandom_range(0, 1100);
    end else if (r < 93) begin
      o = 5'($urandom_range(OP_JAL, OP_JR));
      target = $urandom_range(0, 1 << 16);
      case (o)
        OP_JAL, OP_J: imm = 32'(target) - gen_pc;
        OP_JALR: begin
          rs1 = pick_known(32'hFFFF_FFFF);
          imm = 32'(target) - known_val[rs1];
        end
        default: rs1 = pick_known(32'h0100_0000);
      endcase
    end else if (r < 96) begin
      o = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      // base and offset left random: nearly always out of range
      o = 5'($urandom_range(OP_LB, OP_SW));
    end
    issue(o, rd, rs1, rs2, imm);
  endtask

  // result side back-pressure
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) begin
      known_ok[i] = 1'b0;
      known_val[i] = '0;
    end
    known_ok[0] = 1'b1;
    known_ok[2] = 1'b1;
    known_val[2] = 32'(MEM_BYTES_DEF);
    gen_pc = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(OP_LI,   5'd1,  5'd0,  5'd0,  32'hFFFF_FFFF);
    issue(OP_LI,   5'd31, 5'd0,  5'd0,  32'h7FFF_FFFF);
    issue(OP_LI,   5'd0,  5'd0,  5'd0,  32'h8000_0000);  // x0 stays zero
    issue(OP_ADD,  5'd4,  5'd1,  5'd31, 32'd0);
    issue(OP_SUB,  5'd5,  5'd31, 5'd1,  32'd0);
    issue(OP_XOR,  5'd6,  5'd1,  5'd31, 32'd0);
    issue(OP_ADDI, 5'd7,  5'd31, 5'd0,  32'd1);
    issue(OP_XORI, 5'd8,  5'd1,  5'd0,  32'h8000_0000);
    issue(OP_SLLI, 5'd9,  5'd1,  5'd0,  32'd31);
    issue(OP_SRLI, 5'd10, 5'd1,  5'd0,  32'hFFFF_FFE1);  // only low five bits count
    issue(OP_MV,   5'd11, 5'd2,  5'd0,  32'd0);
    issue(OP_NEG,  5'd12, 5'd31, 5'd0,  32'd0);
    issue(OP_NOT,  5'd13, 5'd0,  5'd0,  32'd0);
    issue(OP_SB,   5'd0,  5'd0,  5'd1,  32'd0);
    issue(OP_LB,   5'd14, 5'd0,  5'd0,  32'd0);          // sign-extended byte
    issue(OP_SW,   5'd0,  5'd2,  5'd31, -32'd4);         // last word below the stack pointer
    issue(OP_LW,   5'd15, 5'd2,  5'd0,  -32'd4);
    issue(OP_LW,   5'd16, 5'd0,  5'd0,  32'd1019);       // unaligned
    issue(OP_LB,   5'd17, 5'd0,  5'd0,  32'd1023);
    issue(OP_LW,   5'd18, 5'd0,  5'd0,  32'd1021);       // straddles the end
    issue(OP_SW,   5'd0,  5'd0,  5'd1,  32'd1024);
    issue(OP_SB,   5'd0,  5'd0,  5'd1,  32'hFFFF_FFFF);
    issue(OP_FIRST_UNUSED, 5'd3, 5'd1, 5'd1, 32'd5);
    issue(OP_LAST_UNUSED,  5'd3, 5'd1, 5'd1, 32'd5);
    issue(OP_JAL,  5'd19, 5'd0,  5'd0,  32'd6);
    issue(OP_JALR, 5'd20, 5'd2,  5'd0,  -32'd3);         // odd target, bit 0 dropped
    issue(OP_J,    5'd0,  5'd0,  5'd0,  32'd0 - gen_pc); // backwards to zero
    issue(OP_JR,   5'd0,  5'd2,  5'd0,  32'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == QUIET_FROM) quiet = 1'b1;
      if (i == DRAIN_AT) drain();
      if (!quiet && $urandom_range(0, 7) == 0) pause($urandom_range(1, 18));
      random_request();
    end

    // run the pc up to the sign boundary, then keep sending while halted
    issue(OP_J,    5'd0, 5'd0, 5'd0, 32'h7FFF_FFFC - gen_pc);
    issue(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'd1);
    issue(OP_SW,   5'd0, 5'd0, 5'd1, 32'd0);
    issue(OP_JAL,  5'd1, 5'd0, 5'd0, -32'd8);
    issue(OP_LI,   5'd3, 5'd0, 5'd0, 32'd7);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
sv/rv32x_pkg.sv
sv/rv32x_ram.sv
sv/rv32x_alu.sv
sv/rv32_subset_execute_unit.sv
dv/rv32x_retire_checker.sv
dv/tb_rv32_subset_execute_unit.sv
